### src/particle_emit_update_engine_macros.svh
// ----------------------------------------------------------------------------
// Particle emit/update engine assertion macros
// Shorthand for clocked, reset-qualified checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_EMIT_UPDATE_ENGINE_MACROS_SVH
`define PARTICLE_EMIT_UPDATE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PEU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("particle engine check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("particle engine check failed");

`endif

### src/peu_pkg.sv
// ----------------------------------------------------------------------------
// Particle emit/update engine package
// Shared types, register indexes, reset values and arithmetic helpers.
// ----------------------------------------------------------------------------
package peu_pkg;

  // Configuration channel widths and register indexes.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegStartColor    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegEndColor      = 4'd1;
  localparam logic [CfgIdxW-1:0] RegSizeRange     = 4'd2;
  localparam logic [CfgIdxW-1:0] RegLifeSetting   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegGravityVector = 4'd4;
  localparam logic [CfgIdxW-1:0] RegBaseVelocity  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegVelSpread     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegGravityOn     = 4'd7;

  // Register reset values.
  localparam logic [23:0] RstStartColor    = 24'd16750874;
  localparam logic [23:0] RstEndColor      = 24'd13382413;
  localparam logic [31:0] RstSizeRange     = 32'd214761882;
  localparam logic [31:0] RstLifeSetting   = 32'd107348378;
  localparam logic [47:0] RstGravityVector = 48'd4160749568;
  localparam logic [47:0] RstBaseVelocity  = 48'd0;
  localparam logic [47:0] RstVelSpread     = 48'd3298585215232;

  // Random generator constants.
  localparam logic [31:0] LcgMul    = 32'd1103515245;
  localparam logic [31:0] LcgInc    = 32'd12345;
  localparam logic [31:0] SeedReset = 32'd123456789;

  // Step conversion: dt = (step_ms * 64 + 500) / 1000 as a reciprocal product.
  localparam logic [22:0] DtBias  = 23'd500;
  localparam logic [23:0] DtRecip = 24'd8589935;

  // One whole particle in the Q16.16 emit accumulator.
  localparam logic [31:0] FracOne = 32'h0001_0000;

  // Depth of the job queue between front and back.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [23:0] start_color;
    logic [23:0] end_color;
    logic [31:0] size_range;
    logic [31:0] life_setting;
    logic [47:0] gravity_vector;
    logic [47:0] base_velocity;
    logic [47:0] velocity_spread;
    logic        gravity_on;
  } peu_cfg_t;

  // A classified job as it travels from front to back.
  typedef struct packed {
    logic        op;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] origin_z;
    logic [31:0] emit_amount;
    logic [15:0] dt;
  } peu_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT_ACC,
    ST_EMIT_TEST,
    ST_EMIT_RAND,
    ST_EMIT_DRAW,
    ST_EMIT_WRITE,
    ST_EMIT_DONE,
    ST_UPD_SCAN,
    ST_UPD_AGE,
    ST_UPD_MOVE,
    ST_UPD_DIV,
    ST_UPD_LERP,
    ST_UPD_WRITE,
    ST_OUT_SCAN,
    ST_OUT_SEND,
    ST_OUT_EMPTY
  } peu_state_e;

  // Pick one axis out of a packed x,y,z vector, x in the top field.
  function automatic logic [15:0] axis_of(logic [47:0] v, logic [1:0] a);
    logic [15:0] r;
    case (a)
      2'd0:    r = v[47:32];
      2'd1:    r = v[31:16];
      default: r = v[15:0];
    endcase
    return r;
  endfunction

  // Clamp a signed sum to the signed 16-bit range.
  function automatic logic [15:0] sat16(logic signed [23:0] v);
    logic [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/peu_if.sv
// ----------------------------------------------------------------------------
// Particle emit/update engine channels
// Valid/ready interfaces for input items, result records and register writes.
// ----------------------------------------------------------------------------
interface peu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] origin_z;
  logic [15:0] emit_rate;
  logic [15:0] emit_interval;
  logic [15:0] step_ms;

  modport source (output valid, op, origin_x, origin_y, origin_z, emit_rate,
                  emit_interval, step_ms, input ready);
  modport sink (input valid, op, origin_x, origin_y, origin_z, emit_rate,
                emit_interval, step_ms, output ready);
endinterface

interface peu_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] size;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [6:0]  live_total;
  logic        last;

  modport source (output valid, valid_res, pos_x, pos_y, pos_z, size, red, green,
                  blue, live_total, last, input ready);
  modport sink (input valid, valid_res, pos_x, pos_y, pos_z, size, red, green,
                blue, live_total, last, output ready);
endinterface

interface peu_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/particle_emit_update_engine.sv
// ----------------------------------------------------------------------------
// Particle emit/update engine
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
// An emit transaction adds its amount, then draws and writes each particle
// created in turn, and returns one empty record. An update transaction
// walks all PARTICLE_SLOTS slots: a free slot is skipped, a retiring one is
// freed, and a survivor takes six motion and four interpolation steps on the
// shared multiplier and the 16-step bit-serial divider. A report pass then
// walks up to the last survivor's record, waiting while the result side
// stalls, or gives one empty record if none survive. Jobs are taken one at a
// time, but a two-entry queue lets the input side accept further transactions
// meanwhile. No clearing pass follows reset; slot data is only used once written.
module particle_emit_update_engine #(
  parameter int unsigned PARTICLE_SLOTS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  peu_in_if.sink     in_i,
  peu_out_if.source  out_o,
  peu_cfg_if.sink    cfg_i
);

  peu_pkg::peu_cfg_t cfg_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  peu_pkg::peu_job_t push_job, pop_job;

  // Register writes are always accepted; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_color     <= peu_pkg::RstStartColor;
      cfg_q.end_color       <= peu_pkg::RstEndColor;
      cfg_q.size_range      <= peu_pkg::RstSizeRange;
      cfg_q.life_setting    <= peu_pkg::RstLifeSetting;
      cfg_q.gravity_vector  <= peu_pkg::RstGravityVector;
      cfg_q.base_velocity   <= peu_pkg::RstBaseVelocity;
      cfg_q.velocity_spread <= peu_pkg::RstVelSpread;
      cfg_q.gravity_on      <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        peu_pkg::RegStartColor:    cfg_q.start_color     <= cfg_i.data[23:0];
        peu_pkg::RegEndColor:      cfg_q.end_color       <= cfg_i.data[23:0];
        peu_pkg::RegSizeRange:     cfg_q.size_range      <= cfg_i.data[31:0];
        peu_pkg::RegLifeSetting:   cfg_q.life_setting    <= cfg_i.data[31:0];
        peu_pkg::RegGravityVector: cfg_q.gravity_vector  <= cfg_i.data;
        peu_pkg::RegBaseVelocity:  cfg_q.base_velocity   <= cfg_i.data;
        peu_pkg::RegVelSpread:     cfg_q.velocity_spread <= cfg_i.data;
        peu_pkg::RegGravityOn:     cfg_q.gravity_on      <= cfg_i.data[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front end: accept and classify transactions.
  peu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  // Job queue between the two halves.
  peu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  // Back end: particle store and arithmetic.
  peu_back #(
    .PARTICLE_SLOTS (PARTICLE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

### src/peu_front.sv
// ----------------------------------------------------------------------------
// Particle engine front end
// Accepts input transactions and turns them into jobs for the back end.
// ----------------------------------------------------------------------------
module peu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  peu_in_if.sink            in_i,
  output logic              push_valid_o,
  output peu_pkg::peu_job_t push_job_o,
  input  logic              push_ready_i
);

  logic        held_q, held_d;
  logic        op_q;
  logic [15:0] ox_q, oy_q, oz_q, rate_q, interval_q, step_q;
  logic [22:0] dt_num;
  logic [46:0] dt_prod;
  logic [31:0] amount;

  // Take a new transaction when the holding stage is empty or draining.
  assign in_i.ready = !held_q || push_ready_i;

  always_comb begin
    held_d = held_q;
    if (in_i.valid && in_i.ready) begin
      held_d = 1'b1;
    end else if (push_ready_i) begin
      held_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q       <= in_i.op;
      ox_q       <= in_i.origin_x;
      oy_q       <= in_i.origin_y;
      oz_q       <= in_i.origin_z;
      rate_q     <= in_i.emit_rate;
      interval_q <= in_i.emit_interval;
      step_q     <= in_i.step_ms;
    end
  end

  // Millisecond step to Q10.6 seconds, rounded, by reciprocal multiply.
  assign dt_num  = {1'b0, step_q, 6'b0} + peu_pkg::DtBias;
  assign dt_prod = {24'b0, dt_num} * {23'b0, peu_pkg::DtRecip};
  assign amount  = rate_q * interval_q;

  always_comb begin
    push_job_o.op          = op_q;
    push_job_o.origin_x    = ox_q;
    push_job_o.origin_y    = oy_q;
    push_job_o.origin_z    = oz_q;
    push_job_o.emit_amount = amount;
    push_job_o.dt          = {2'b0, dt_prod[46:33]};
  end

  assign push_valid_o = held_q;

endmodule

### src/peu_queue.sv
// ----------------------------------------------------------------------------
// Particle engine job queue
// Short FIFO that lets the front end and back end stall independently.
// ----------------------------------------------------------------------------
module peu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  peu_pkg::peu_job_t push_job_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output peu_pkg::peu_job_t pop_job_o,
  input  logic              pop_ready_i
);

  localparam int unsigned PtrW = $clog2(peu_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(peu_pkg::QueueDepth + 1);

  peu_pkg::peu_job_t entry_q [peu_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(peu_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(peu_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(peu_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### src/peu_back.sv
// ----------------------------------------------------------------------------
// Particle engine back end
// Sequencer that emits, ages, integrates and reports particles in the slot
// memory, with one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module peu_back #(
  parameter int unsigned PARTICLE_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  peu_pkg::peu_cfg_t cfg_i,
  input  logic              job_valid_i,
  input  peu_pkg::peu_job_t job_i,
  output logic              job_ready_o,
  peu_out_if.source         out_o
);

  localparam int unsigned SlotW = $clog2(PARTICLE_SLOTS);
  localparam int unsigned WalkW = $clog2(PARTICLE_SLOTS + 1);

  // One stored particle; vectors are indexed by axis, x first.
  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] vel;
    logic [15:0]      age;
    logic [15:0]      lifespan;
    logic [15:0]      size;
    logic [2:0][7:0]  color;
  } slot_t;

  peu_pkg::peu_state_e state_q, state_d;

  // Control state.
  logic [SlotW-1:0]    next_slot_q, slot_q;
  logic [WalkW-1:0]    walk_q, surv_q, sent_q;
  logic [6:0]          live_cnt_q;
  logic [31:0]         frac_q, seed_q;
  logic [PARTICLE_SLOTS-1:0] live_q;
  logic [2:0]          sub_q;
  logic [3:0]          div_q;
  logic                out_valid_q;

  // Payload and work registers.
  peu_pkg::peu_job_t   job_q;
  logic [2:0][15:0]    pos_q, vel_q;
  logic [15:0]         life_q, rem_q, quo_q, size_q, age_q;
  logic [2:0][7:0]     col_q;
  slot_t               mem_q [PARTICLE_SLOTS];
  slot_t               rd_q, wr_data;
  logic [SlotW-1:0]    wr_addr;

  // Output record registers.
  logic                res_valid_q, res_last_q;
  logic [2:0][15:0]    res_pos_q;
  logic [15:0]         res_size_q;
  logic [2:0][7:0]     res_col_q;
  logic [6:0]          res_total_q;

  // Control strobes.
  logic q_pop, slot_adv, mem_we, out_load, out_free;

  // Derived values.
  logic [15:0]        rnd;
  logic               cur_live, walk_done, can_emit, retire, last_out;
  logic [16:0]        age_sum;
  logic [15:0]        age_new;
  logic [2:0]         sub_m3;
  logic [1:0]         axis;
  logic [SlotW-1:0]   slot_inc, next_inc;
  logic [32:0]        frac_sum;
  logic [16:0]        rem2;
  logic               rem_ge;
  logic [15:0]        lerp_s, lerp_e;
  logic [16:0]        lerp_diff;
  logic [16:0]        life_sum;
  logic [15:0]        base_ax, grav_ax;

  // Shared multiplier.
  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] mul_p;

  assign rnd       = seed_q[30:15];
  assign cur_live  = live_q[slot_q];
  assign walk_done = walk_q == WalkW'(PARTICLE_SLOTS);
  assign can_emit  = (frac_q >= peu_pkg::FracOne) && (live_cnt_q < 7'(PARTICLE_SLOTS));
  assign age_sum   = {1'b0, rd_q.age} + {1'b0, job_q.dt};
  assign age_new   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
  assign retire    = age_new >= rd_q.lifespan;
  assign last_out  = (sent_q + 1'b1) == surv_q;
  assign sub_m3    = sub_q - 3'd3;
  assign axis      = (sub_q < 3'd3) ? sub_q[1:0] : sub_m3[1:0];
  assign slot_inc  = (slot_q == SlotW'(PARTICLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign next_inc  = (next_slot_q == SlotW'(PARTICLE_SLOTS - 1)) ? '0 : next_slot_q + 1'b1;
  assign frac_sum  = {1'b0, frac_q} + {1'b0, job_q.emit_amount};
  assign rem2      = {rem_q, 1'b0};
  assign rem_ge    = rem2 >= {1'b0, life_q};
  assign out_free  = !out_valid_q || out_o.ready;
  assign base_ax   = peu_pkg::axis_of(cfg_i.base_velocity, sub_q[1:0]);
  assign grav_ax   = peu_pkg::axis_of(cfg_i.gravity_vector, axis);

  // Start and end values for the interpolation step in progress.
  always_comb begin
    case (sub_q)
      3'd0: begin
        lerp_s = cfg_i.size_range[31:16];
        lerp_e = cfg_i.size_range[15:0];
      end
      3'd1: begin
        lerp_s = {8'b0, cfg_i.start_color[23:16]};
        lerp_e = {8'b0, cfg_i.end_color[23:16]};
      end
      3'd2: begin
        lerp_s = {8'b0, cfg_i.start_color[15:8]};
        lerp_e = {8'b0, cfg_i.end_color[15:8]};
      end
      default: begin
        lerp_s = {8'b0, cfg_i.start_color[7:0]};
        lerp_e = {8'b0, cfg_i.end_color[7:0]};
      end
    endcase
  end
  assign lerp_diff = {1'b0, lerp_e} - {1'b0, lerp_s};

  // Multiplier operand selection by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      peu_pkg::ST_EMIT_DRAW: begin
        if (sub_q < 3'd3) begin
          mul_a = $signed({1'b0, rnd, 1'b0}) - 18'sd65536;
          mul_b = $signed({1'b0, peu_pkg::axis_of(cfg_i.velocity_spread, sub_q[1:0])});
        end else begin
          mul_a = $signed({2'b00, rnd});
          mul_b = $signed({1'b0, cfg_i.life_setting[15:0]});
        end
      end
      peu_pkg::ST_UPD_MOVE: begin
        if (sub_q < 3'd3) begin
          mul_a = $signed({{2{vel_q[axis][15]}}, vel_q[axis]});
        end else begin
          mul_a = $signed({{2{grav_ax[15]}}, grav_ax});
        end
        mul_b = $signed({1'b0, job_q.dt});
      end
      peu_pkg::ST_UPD_LERP: begin
        mul_a = $signed({lerp_diff[16], lerp_diff});
        mul_b = $signed({1'b0, quo_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p    = mul_a * mul_b;
  assign life_sum = {1'b0, cfg_i.life_setting[31:16]} + {1'b0, mul_p[31:16]};

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      peu_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.op ? peu_pkg::ST_UPD_SCAN : peu_pkg::ST_EMIT_ACC;
        end
      end
      peu_pkg::ST_EMIT_ACC:  state_d = peu_pkg::ST_EMIT_TEST;
      peu_pkg::ST_EMIT_TEST: begin
        state_d = can_emit ? peu_pkg::ST_EMIT_RAND : peu_pkg::ST_EMIT_DONE;
      end
      peu_pkg::ST_EMIT_RAND: state_d = peu_pkg::ST_EMIT_DRAW;
      peu_pkg::ST_EMIT_DRAW: begin
        state_d = (sub_q == 3'd3) ? peu_pkg::ST_EMIT_WRITE : peu_pkg::ST_EMIT_RAND;
      end
      peu_pkg::ST_EMIT_WRITE: state_d = peu_pkg::ST_EMIT_TEST;
      peu_pkg::ST_EMIT_DONE: begin
        if (out_free) begin
          state_d = peu_pkg::ST_IDLE;
        end
      end
      peu_pkg::ST_UPD_SCAN: begin
        if (walk_done) begin
          state_d = (surv_q == '0) ? peu_pkg::ST_OUT_EMPTY : peu_pkg::ST_OUT_SCAN;
        end else if (cur_live) begin
          state_d = peu_pkg::ST_UPD_AGE;
        end
      end
      peu_pkg::ST_UPD_AGE: begin
        state_d = retire ? peu_pkg::ST_UPD_SCAN : peu_pkg::ST_UPD_MOVE;
      end
      peu_pkg::ST_UPD_MOVE: begin
        if (sub_q == 3'd5) begin
          state_d = peu_pkg::ST_UPD_DIV;
        end
      end
      peu_pkg::ST_UPD_DIV: begin
        if (div_q == 4'd15) begin
          state_d = peu_pkg::ST_UPD_LERP;
        end
      end
      peu_pkg::ST_UPD_LERP: begin
        if (sub_q == 3'd3) begin
          state_d = peu_pkg::ST_UPD_WRITE;
        end
      end
      peu_pkg::ST_UPD_WRITE: state_d = peu_pkg::ST_UPD_SCAN;
      peu_pkg::ST_OUT_SCAN: begin
        if (cur_live) begin
          state_d = peu_pkg::ST_OUT_SEND;
        end
      end
      peu_pkg::ST_OUT_SEND: begin
        if (out_free) begin
          state_d = last_out ? peu_pkg::ST_IDLE : peu_pkg::ST_OUT_SCAN;
        end
      end
      peu_pkg::ST_OUT_EMPTY: begin
        if (out_free) begin
          state_d = peu_pkg::ST_IDLE;
        end
      end
      default: state_d = peu_pkg::ST_IDLE;
    endcase
  end

  // Control strobes decoded from the state.
  always_comb begin
    q_pop    = 1'b0;
    slot_adv = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      peu_pkg::ST_IDLE:       q_pop = 1'b1;
      peu_pkg::ST_EMIT_WRITE: mem_we = 1'b1;
      peu_pkg::ST_EMIT_DONE:  out_load = out_free;
      peu_pkg::ST_UPD_SCAN:   slot_adv = !walk_done && !cur_live;
      peu_pkg::ST_UPD_AGE:    slot_adv = retire;
      peu_pkg::ST_UPD_WRITE: begin
        mem_we   = 1'b1;
        slot_adv = 1'b1;
      end
      peu_pkg::ST_OUT_SCAN:   slot_adv = !cur_live;
      peu_pkg::ST_OUT_SEND: begin
        slot_adv = out_free;
        out_load = out_free;
      end
      peu_pkg::ST_OUT_EMPTY:  out_load = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign job_ready_o = q_pop;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= peu_pkg::ST_IDLE;
      next_slot_q <= '0;
      slot_q      <= '0;
      walk_q      <= '0;
      surv_q      <= '0;
      sent_q      <= '0;
      live_cnt_q  <= '0;
      frac_q      <= '0;
      seed_q      <= peu_pkg::SeedReset;
      live_q      <= '0;
      sub_q       <= '0;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        peu_pkg::ST_IDLE: begin
          slot_q <= next_slot_q;
          walk_q <= '0;
          surv_q <= '0;
          sent_q <= '0;
        end
        peu_pkg::ST_EMIT_ACC: begin
          frac_q <= frac_sum[32] ? 32'hFFFF_FFFF : frac_sum[31:0];
        end
        peu_pkg::ST_EMIT_TEST: sub_q <= '0;
        peu_pkg::ST_EMIT_RAND: seed_q <= seed_q * peu_pkg::LcgMul + peu_pkg::LcgInc;
        peu_pkg::ST_EMIT_DRAW: sub_q <= sub_q + 1'b1;
        peu_pkg::ST_EMIT_WRITE: begin
          live_q[next_slot_q] <= 1'b1;
          next_slot_q         <= next_inc;
          live_cnt_q          <= live_cnt_q + 1'b1;
          frac_q              <= frac_q - peu_pkg::FracOne;
        end
        peu_pkg::ST_UPD_SCAN: begin
          if (walk_done) begin
            slot_q <= next_slot_q;
            walk_q <= '0;
          end
        end
        peu_pkg::ST_UPD_AGE: begin
          sub_q <= '0;
          if (retire) begin
            live_q[slot_q] <= 1'b0;
            if (live_cnt_q != '0) begin
              live_cnt_q <= live_cnt_q - 1'b1;
            end
          end else begin
            surv_q <= surv_q + 1'b1;
          end
        end
        peu_pkg::ST_UPD_MOVE: begin
          sub_q <= (sub_q == 3'd5) ? 3'd0 : sub_q + 1'b1;
          div_q <= '0;
        end
        peu_pkg::ST_UPD_DIV:  div_q <= div_q + 1'b1;
        peu_pkg::ST_UPD_LERP: sub_q <= sub_q + 1'b1;
        peu_pkg::ST_OUT_SEND: begin
          if (out_free) begin
            sent_q <= sent_q + 1'b1;
          end
        end
        default: begin
          sub_q <= sub_q;
        end
      endcase
      if (slot_adv) begin
        slot_q <= slot_inc;
        walk_q <= walk_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work registers for the particle in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      peu_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
        end
      end
      peu_pkg::ST_EMIT_DRAW: begin
        if (sub_q < 3'd3) begin
          vel_q[sub_q[1:0]] <= peu_pkg::sat16({{8{base_ax[15]}}, base_ax} +
                                              {{5{mul_p[34]}}, mul_p[34:16]});
        end else begin
          life_q <= life_sum[16] ? 16'hFFFF : life_sum[15:0];
        end
      end
      peu_pkg::ST_UPD_AGE: begin
        pos_q  <= rd_q.pos;
        vel_q  <= rd_q.vel;
        life_q <= rd_q.lifespan;
        rem_q  <= age_new;
        age_q  <= age_new;
      end
      peu_pkg::ST_UPD_MOVE: begin
        if (sub_q < 3'd3) begin
          pos_q[axis] <= peu_pkg::sat16({{8{pos_q[axis][15]}}, pos_q[axis]} +
                                        {mul_p[34], mul_p[34:12]});
        end else if (cfg_i.gravity_on) begin
          vel_q[axis] <= peu_pkg::sat16({{8{vel_q[axis][15]}}, vel_q[axis]} +
                                        {mul_p[34], mul_p[34:12]});
        end
      end
      peu_pkg::ST_UPD_DIV: begin
        rem_q <= rem_ge ? 16'(rem2 - {1'b0, life_q}) : rem2[15:0];
        quo_q <= {quo_q[14:0], rem_ge};
      end
      peu_pkg::ST_UPD_LERP: begin
        if (sub_q == 3'd0) begin
          size_q <= lerp_s + mul_p[31:16];
        end else begin
          col_q[sub_m3[1:0] + 2'd2] <= 8'(lerp_s + mul_p[31:16]);
        end
      end
      default: begin
        life_q <= life_q;
      end
    endcase
  end

  // Slot memory, one write port and one registered read port.
  always_comb begin
    if (state_q == peu_pkg::ST_EMIT_WRITE) begin
      wr_addr          = next_slot_q;
      wr_data.pos[0]   = job_q.origin_x;
      wr_data.pos[1]   = job_q.origin_y;
      wr_data.pos[2]   = job_q.origin_z;
      wr_data.vel      = vel_q;
      wr_data.age      = '0;
      wr_data.lifespan = life_q;
      wr_data.size     = '0;
      wr_data.color    = '0;
    end else begin
      wr_addr          = slot_q;
      wr_data.pos      = pos_q;
      wr_data.vel      = vel_q;
      wr_data.age      = age_q;
      wr_data.lifespan = life_q;
      wr_data.size     = size_q;
      wr_data.color    = col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[slot_q];
  end

  // Result register, loaded when a record is offered.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_total_q <= live_cnt_q;
      if (state_q == peu_pkg::ST_OUT_SEND) begin
        res_valid_q <= 1'b1;
        res_last_q  <= last_out;
        res_pos_q   <= rd_q.pos;
        res_size_q  <= rd_q.size;
        res_col_q   <= rd_q.color;
      end else begin
        res_valid_q <= 1'b0;
        res_last_q  <= 1'b1;
        res_pos_q   <= '0;
        res_size_q  <= '0;
        res_col_q   <= '0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.valid_res  = res_valid_q;
  assign out_o.pos_x      = res_pos_q[0];
  assign out_o.pos_y      = res_pos_q[1];
  assign out_o.pos_z      = res_pos_q[2];
  assign out_o.size       = res_size_q;
  assign out_o.red        = res_col_q[0];
  assign out_o.green      = res_col_q[1];
  assign out_o.blue       = res_col_q[2];
  assign out_o.live_total = res_total_q;
  assign out_o.last       = res_last_q;

endmodule

### src/peu_checker.sv
// ----------------------------------------------------------------------------
// Particle emit/update engine checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_emit_update_engine_macros.svh"

module peu_checker #(
  parameter int unsigned PARTICLE_SLOTS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       valid_res_i,
  input logic       last_i,
  input logic [6:0] live_total_i
);

  // A stalled result transaction stays offered with the same count.
  `PEU_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(live_total_i))

  // An empty record is always the final one of its item.
  `PEU_ASSERT_NOW(a_empty_last, out_valid_i && !valid_res_i, last_i)

  // The live count never exceeds the slot count.
  `PEU_ASSERT_NOW(a_total_range, out_valid_i, live_total_i <= 7'(PARTICLE_SLOTS))

  // A particle record implies at least one live particle.
  `PEU_ASSERT_NOW(a_rec_nonzero, out_valid_i && valid_res_i, live_total_i != 7'd0)

endmodule

bind particle_emit_update_engine peu_checker #(
  .PARTICLE_SLOTS (PARTICLE_SLOTS)
) u_peu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .valid_res_i  (out_o.valid_res),
  .last_i       (out_o.last),
  .live_total_i (out_o.live_total)
);

### verif/particle_emit_update_engine_test.sv
// ----------------------------------------------------------------------------
// Particle emit/update engine testbench
// Drives emit and update transactions with random gaps on both channels,
// predicts every particle record in a cycle-free model of the slot ring, and
// checks each record field by field across several register settings.
// ----------------------------------------------------------------------------
module particle_emit_update_engine_test;

  localparam int unsigned Slots     = 64;
  localparam int unsigned DrainWait = 400;
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned HoldLen   = 600;
  localparam logic        OpEmit    = 1'b0;
  localparam logic        OpUpdate  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] origin_z;
    logic [15:0] emit_rate;
    logic [15:0] emit_interval;
    logic [15:0] step_ms;
  } stim_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] size;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  live_total;
    logic        last;
  } particle_rec_t;

  logic clk_i;
  logic rst_ni;

  peu_in_if  in_if ();
  peu_out_if out_if ();
  peu_cfg_if cfg_if ();

  particle_emit_update_engine #(
    .PARTICLE_SLOTS(Slots)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Testbench state shared by the processes below.
  stim_item_t    pending_items[$];
  particle_rec_t expected_records[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            in_taken;
  int unsigned   in_gap;
  int unsigned   out_gap;
  int unsigned   hold_left;
  bit            hold_req;
  bit            hold_started;
  bit            calm;

  // Predicted engine state; registers are indexed by the full index width.
  logic [47:0]        reg_value[16];
  logic signed [15:0] ring_pos[Slots][3];
  logic signed [15:0] ring_vel[Slots][3];
  logic [15:0]        ring_age[Slots];
  logic [15:0]        ring_life[Slots];
  bit                 ring_live[Slots];
  logic [39:0]        ring_look[Slots];
  int unsigned        ring_next;
  int unsigned        live_count;
  logic [31:0]        emit_acc;
  logic [31:0]        lcg_state;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [47:0] reg_mask(int unsigned idx);
    logic [47:0] m;
    case (idx)
      peu_pkg::RegStartColor, peu_pkg::RegEndColor: m = 48'hFF_FFFF;
      peu_pkg::RegSizeRange, peu_pkg::RegLifeSetting: m = 48'hFFFF_FFFF;
      peu_pkg::RegGravityOn: m = 48'h1;
      default: m = 48'hFFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] clamp_s16(longint v);
    logic [15:0] r;
    if (v > 32767) begin
      r = 16'h7FFF;
    end else if (v < -32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] field_of(logic [47:0] pack, int k);
    return pack[47 - 16 * k -: 16];
  endfunction

  function automatic longint lcg_draw();
    lcg_state = lcg_state * peu_pkg::LcgMul + peu_pkg::LcgInc;
    return longint'(lcg_state[30:15]);
  endfunction

  function automatic longint blend(longint s, longint e, longint t);
    return (s * (65536 - t) + e * t) >> 16;
  endfunction

  function automatic particle_rec_t empty_record();
    particle_rec_t r;
    r = '0;
    r.live_total = live_count[6:0];
    r.last = 1'b1;
    return r;
  endfunction

  // Emit: add to the accumulator and fill whole particles into the ring.
  function automatic void predict_emit(stim_item_t it);
    longint sum;
    longint dir;
    longint life;
    int unsigned s;
    sum = longint'(emit_acc) + longint'(it.emit_rate) * longint'(it.emit_interval);
    emit_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    while (emit_acc >= peu_pkg::FracOne && live_count < Slots) begin
      s = ring_next;
      for (int k = 0; k < 3; k++) begin
        dir = 2 * lcg_draw() - 65536;
        ring_pos[s][k] = (k == 0) ? it.origin_x : (k == 1) ? it.origin_y : it.origin_z;
        ring_vel[s][k] = clamp_s16(
            longint'($signed(field_of(reg_value[peu_pkg::RegBaseVelocity], k)))
            + ((dir * longint'(field_of(reg_value[peu_pkg::RegVelSpread], k))) >>> 16));
      end
      life = longint'(reg_value[peu_pkg::RegLifeSetting][31:16])
          + ((lcg_draw() * longint'(reg_value[peu_pkg::RegLifeSetting][15:0])) >> 16);
      ring_life[s] = (life > 65535) ? 16'hFFFF : life[15:0];
      ring_age[s] = '0;
      ring_live[s] = 1'b1;
      ring_next = (s + 1) % Slots;
      live_count++;
      emit_acc = emit_acc - peu_pkg::FracOne;
    end
    expected_records.push_back(empty_record());
  endfunction

  // Update: age, retire, integrate and restyle every live slot, then report.
  function automatic void predict_update(stim_item_t it);
    longint dt;
    longint age;
    longint t;
    longint sz;
    logic [23:0] col;
    int unsigned s;
    int n;
    particle_rec_t r;
    dt = (longint'(it.step_ms) * 64 + 500) / 1000;
    s = ring_next;
    for (int i = 0; i < Slots; i++) begin
      if (ring_live[s]) begin
        age = longint'(ring_age[s]) + dt;
        if (age > 65535) age = 65535;
        ring_age[s] = age[15:0];
        if (age >= longint'(ring_life[s])) begin
          ring_live[s] = 1'b0;
          if (live_count > 0) live_count--;
        end else begin
          for (int k = 0; k < 3; k++) begin
            ring_pos[s][k] = clamp_s16(longint'(ring_pos[s][k])
                + ((longint'(ring_vel[s][k]) * dt) >>> 12));
            if (reg_value[peu_pkg::RegGravityOn][0])
              ring_vel[s][k] = clamp_s16(longint'(ring_vel[s][k])
                  + ((longint'($signed(field_of(reg_value[peu_pkg::RegGravityVector], k)))
                  * dt) >>> 12));
          end
          t = (age << 16) / longint'(ring_life[s]);
          sz = blend(longint'(reg_value[peu_pkg::RegSizeRange][31:16]),
                     longint'(reg_value[peu_pkg::RegSizeRange][15:0]), t);
          for (int c = 0; c < 3; c++) begin
            col[23 - 8 * c -: 8] = 8'(blend(
                longint'(reg_value[peu_pkg::RegStartColor][23 - 8 * c -: 8]),
                longint'(reg_value[peu_pkg::RegEndColor][23 - 8 * c -: 8]),
                t));
          end
          ring_look[s] = {sz[15:0], col};
        end
      end
      s = (s + 1) % Slots;
    end
    n = 0;
    s = ring_next;
    for (int i = 0; i < Slots; i++) begin
      if (ring_live[s]) begin
        r.valid_res  = 1'b1;
        r.pos_x      = ring_pos[s][0];
        r.pos_y      = ring_pos[s][1];
        r.pos_z      = ring_pos[s][2];
        r.size       = ring_look[s][39:24];
        r.red        = ring_look[s][23:16];
        r.green      = ring_look[s][15:8];
        r.blue       = ring_look[s][7:0];
        r.live_total = live_count[6:0];
        r.last       = 1'b0;
        expected_records.push_back(r);
        n++;
      end
      s = (s + 1) % Slots;
    end
    if (n == 0) begin
      expected_records.push_back(empty_record());
    end else begin
      expected_records[$].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Acceptance monitor: predicts on accepted inputs and register writes,
  // checks accepted records, and enforces the cycle cap.
  always @(posedge clk_i) begin
    particle_rec_t want;
    stim_item_t it;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleCap) begin
        $display("Verification failed");
        $finish;
      end else begin
        if (cfg_if.valid && cfg_if.ready && cfg_if.index < 8)
          reg_value[cfg_if.index] = cfg_if.data & reg_mask(cfg_if.index);
        if (in_if.valid && in_if.ready) begin
          in_taken = 1'b1;
          it.op            = in_if.op;
          it.origin_x      = in_if.origin_x;
          it.origin_y      = in_if.origin_y;
          it.origin_z      = in_if.origin_z;
          it.emit_rate     = in_if.emit_rate;
          it.emit_interval = in_if.emit_interval;
          it.step_ms       = in_if.step_ms;
          if (it.op == OpEmit) predict_emit(it);
          else predict_update(it);
        end
        if (out_if.valid && out_if.ready) begin
          if (expected_records.size() == 0) begin
            $error("record arrived with no expectation pending");
            error_count++;
          end else begin
            want = expected_records.pop_front();
            check_field("valid_res", want.valid_res, out_if.valid_res);
            check_field("pos_x", want.pos_x, out_if.pos_x);
            check_field("pos_y", want.pos_y, out_if.pos_y);
            check_field("pos_z", want.pos_z, out_if.pos_z);
            check_field("size", want.size, out_if.size);
            check_field("red", want.red, out_if.red);
            check_field("green", want.green, out_if.green);
            check_field("blue", want.blue, out_if.blue);
            check_field("live_total", want.live_total, out_if.live_total);
            check_field("last", want.last, out_if.last);
          end
        end
      end
    end
  end

  // Input driver: presents queued items with random gaps.
  always @(negedge clk_i) begin
    stim_item_t it;
    if (rst_ni && !(in_if.valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        if (!calm && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 3) - 1;
          in_if.valid <= 1'b0;
        end else begin
          it = pending_items.pop_front();
          in_if.op            <= it.op;
          in_if.origin_x      <= it.origin_x;
          in_if.origin_y      <= it.origin_y;
          in_if.origin_z      <= it.origin_z;
          in_if.emit_rate     <= it.emit_rate;
          in_if.emit_interval <= it.emit_interval;
          in_if.step_ms       <= it.step_ms;
          in_if.valid         <= 1'b1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stall bursts and one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 3) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic stim_item_t emit_item(logic [15:0] ox, logic [15:0] oy,
                                           logic [15:0] oz, logic [15:0] rate,
                                           logic [15:0] ivl);
    stim_item_t it;
    it.op = OpEmit;
    it.origin_x = ox;
    it.origin_y = oy;
    it.origin_z = oz;
    it.emit_rate = rate;
    it.emit_interval = ivl;
    it.step_ms = 16'($urandom());
    return it;
  endfunction

  function automatic stim_item_t update_item(logic [15:0] step);
    stim_item_t it;
    it = emit_item(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()));
    it.op = OpUpdate;
    it.step_ms = step;
    return it;
  endfunction

  // Mostly modest bursts and short steps so particles live several updates.
  function automatic stim_item_t random_item(bit wide);
    stim_item_t it;
    if ($urandom_range(0, 1) == 0) begin
      it = emit_item(16'($urandom()), 16'($urandom()), 16'($urandom()),
                     wide ? 16'($urandom()) : 16'($urandom_range(0, 40)),
                     16'($urandom()));
    end else begin
      it = update_item(($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(0, 3000)));
    end
    return it;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_if.valid || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_all(logic [47:0] v0, logic [47:0] v1, logic [47:0] v2,
                           logic [47:0] v3, logic [47:0] v4, logic [47:0] v5,
                           logic [47:0] v6, logic [47:0] v7);
    write_reg(peu_pkg::RegStartColor, v0);
    write_reg(peu_pkg::RegEndColor, v1);
    write_reg(peu_pkg::RegSizeRange, v2);
    write_reg(peu_pkg::RegLifeSetting, v3);
    write_reg(peu_pkg::RegGravityVector, v4);
    write_reg(peu_pkg::RegBaseVelocity, v5);
    write_reg(peu_pkg::RegVelSpread, v6);
    write_reg(peu_pkg::RegGravityOn, v7);
  endtask

  task automatic write_random_regs();
    write_all(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
              48'({$urandom(), $urandom()}),
              48'({16'($urandom_range(800, 6000)), 16'($urandom())}),
              48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
              48'({$urandom(), $urandom()}), 48'($urandom_range(0, 1)));
  endtask

  // Stimulus sequence.
  initial begin
    in_if.valid = 1'b0;
    in_if.op = OpEmit;
    in_if.origin_x = '0;
    in_if.origin_y = '0;
    in_if.origin_z = '0;
    in_if.emit_rate = '0;
    in_if.emit_interval = '0;
    in_if.step_ms = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    error_count = 0;
    cycle_count = 0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_started = 1'b0;
    calm = 1'b0;
    reg_value[peu_pkg::RegStartColor]    = peu_pkg::RstStartColor;
    reg_value[peu_pkg::RegEndColor]      = peu_pkg::RstEndColor;
    reg_value[peu_pkg::RegSizeRange]     = peu_pkg::RstSizeRange;
    reg_value[peu_pkg::RegLifeSetting]   = peu_pkg::RstLifeSetting;
    reg_value[peu_pkg::RegGravityVector] = peu_pkg::RstGravityVector;
    reg_value[peu_pkg::RegBaseVelocity]  = peu_pkg::RstBaseVelocity;
    reg_value[peu_pkg::RegVelSpread]     = peu_pkg::RstVelSpread;
    reg_value[peu_pkg::RegGravityOn]     = 48'd1;
    for (int s = 0; s < Slots; s++) ring_live[s] = 1'b0;
    ring_next = 0;
    live_count = 0;
    emit_acc = '0;
    lcg_state = peu_pkg::SeedReset;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty ring, zero burst, a burst that overfills the store,
    // tiny and huge steps, and retirement of everything.
    pending_items.push_back(update_item(16'd0));
    pending_items.push_back(emit_item(16'h7FFF, 16'h8000, 16'h0000, 16'd0, 16'd0));
    pending_items.push_back(emit_item(16'h7FFF, 16'h8000, 16'h0001, 16'd3, 16'hFFFF));
    pending_items.push_back(update_item(16'd64));
    pending_items.push_back(emit_item(16'h8000, 16'h7FFF, 16'hFFFF, 16'd100, 16'hFFFF));
    pending_items.push_back(update_item(16'd0));
    pending_items.push_back(update_item(16'd64));
    pending_items.push_back(emit_item(16'h1234, 16'hFEDC, 16'h0100, 16'd5, 16'h8000));
    pending_items.push_back(update_item(16'd2000));
    pending_items.push_back(update_item(16'hFFFF));
    pending_items.push_back(update_item(16'd100));
    wait_drained();

    // Random settings with a long result hold-off while the sender keeps going.
    write_random_regs();
    write_reg(4'd9, 48'({$urandom(), $urandom()}));
    hold_req = 1'b1;
    for (int i = 0; i < 35; i++) pending_items.push_back(random_item(1'b0));
    wait_drained();

    // All-zero settings: zero lifetimes retire at once.
    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 15; i++) pending_items.push_back(random_item(1'b0));
    wait_drained();

    // All-ones settings: longest lives, widest spread, full-scale colors.
    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    for (int i = 0; i < 30; i++) pending_items.push_back(random_item(1'b0));
    wait_drained();

    // Last part without idling: full-range rates, then accumulator saturation.
    write_random_regs();
    calm = 1'b1;
    for (int i = 0; i < 25; i++) pending_items.push_back(random_item(1'b1));
    pending_items.push_back(emit_item(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                      16'hFFFF, 16'hFFFF));
    pending_items.push_back(emit_item(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                      16'hFFFF, 16'hFFFF));
    pending_items.push_back(update_item(16'd500));
    pending_items.push_back(update_item(16'hFFFF));
    pending_items.push_back(emit_item(16'd0, 16'd0, 16'd0, 16'd1, 16'd1));
    wait_drained();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/peu_pkg.sv
src/peu_if.sv
src/peu_front.sv
src/peu_queue.sv
src/peu_back.sv
src/particle_emit_update_engine.sv
src/peu_checker.sv
verif/particle_emit_update_engine_test.sv
